[hdl/fpct_pkg.sv]
// ----------------------------------------------------------------------------
// fpct_pkg
// Shared constants, types and controller encoding for the formation pair
// category table.
// ----------------------------------------------------------------------------
`default_nettype none

package fpct_pkg;

    localparam int FORMATION_W       = 8;
    localparam int CATEGORY_W        = 9;
    localparam int FCOUNT_W          = 9;
    localparam int KEY_W             = 2 * FORMATION_W;
    localparam int MAX_PAIRS_DEFAULT = 256;

    typedef logic [FORMATION_W-1:0] formation_t;
    typedef logic [CATEGORY_W-1:0]  category_t;
    typedef logic [FCOUNT_W-1:0]    fcount_t;
    typedef logic [KEY_W-1:0]       pair_key_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } fpct_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;    // capture the accepted connection
        logic search;     // walk the pair table
        logic take_hit;   // resolve as an existing pair
        logic take_miss;  // resolve as a new pair (append or full)
        logic push;       // move the pending result to the output register
    } fpct_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_same;    // incoming indices are equal
        logic hit;        // compared entry matches the key
        logic miss_end;   // every held entry compared, no match
    } fpct_status_t;

endpackage

`default_nettype wire

[hdl/fpct_if.sv]
// ----------------------------------------------------------------------------
// fpct_conn_if / fpct_result_if
// Valid/ready channels for connections in and categories out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpct_conn_if;
    import fpct_pkg::*;

    logic       valid;
    logic       ready;
    formation_t formation_a;
    formation_t formation_b;

    modport source (output valid, output formation_a, output formation_b, input ready);
    modport sink   (input valid, input formation_a, input formation_b, output ready);
endinterface

interface fpct_result_if;
    import fpct_pkg::*;

    logic      valid;
    logic      ready;
    category_t category;
    logic      crossing;
    logic      table_full;

    modport source (output valid, output category, output crossing, output table_full,
                    input ready);
    modport sink   (input valid, input category, input crossing, input table_full,
                    output ready);
endinterface

`default_nettype wire

[hdl/fpct_ram.sv]
// ----------------------------------------------------------------------------
// fpct_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpct_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output      logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/fpct_ctrl.sv]
// ----------------------------------------------------------------------------
// fpct_ctrl
// Sequencer: accept, table walk, result hand-off; owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module fpct_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   conn_valid,
    output      logic                   conn_ready,
    output      logic                   res_valid,
    input  wire logic                   res_ready,
    input  wire fpct_pkg::fpct_status_t status,
    output      fpct_pkg::fpct_cmd_t    cmd
);
    import fpct_pkg::*;

    fpct_state_t state_reg, state_next;
    logic        out_vld_reg, out_vld_next;
    logic        conn_fire;
    logic        out_free;

    assign conn_ready = (state_reg == ST_IDLE);
    assign conn_fire  = conn_valid && conn_ready;
    assign out_free   = !out_vld_reg || res_ready;
    assign res_valid  = out_vld_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (conn_fire)
                begin
                    state_next = status.in_same ? ST_DONE : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.hit || status.miss_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = conn_fire;
            end
            ST_SEARCH:
            begin
                cmd.search    = 1'b1;
                cmd.take_hit  = status.hit;
                cmd.take_miss = status.miss_end;
            end
            ST_DONE:
            begin
                cmd.push = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.push)
        begin
            out_vld_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

`default_nettype wire

[hdl/fpct_dp.sv]
// ----------------------------------------------------------------------------
// fpct_dp
// Datapath: key build, pipelined table compare, pair count, category adder,
// pending and output result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fpct_dp #(
    parameter  int MAX_PAIRS = fpct_pkg::MAX_PAIRS_DEFAULT,
    localparam int AW        = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire fpct_pkg::fpct_cmd_t    cmd,
    output      fpct_pkg::fpct_status_t status,
    input  wire logic                   cfg_wr_en,
    input  wire fpct_pkg::fcount_t      cfg_wr_data,
    input  wire fpct_pkg::formation_t   formation_a,
    input  wire fpct_pkg::formation_t   formation_b,
    output      fpct_pkg::category_t    category,
    output      logic                   crossing,
    output      logic                   table_full,
    output      logic                   ram_wr_en,
    output      logic [AW-1:0]          ram_wr_addr,
    output      fpct_pkg::pair_key_t    ram_wr_data,
    output      logic                   ram_rd_en,
    output      logic [AW-1:0]          ram_rd_addr,
    input  wire fpct_pkg::pair_key_t    ram_rd_data
);
    import fpct_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W = (CNT_W > CATEGORY_W) ? CNT_W : CATEGORY_W;

    fcount_t          fcount_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    pair_key_t        key_reg, key_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    category_t        res_cat_reg, res_cat_next;
    logic             res_cross_reg, res_cross_next;
    logic             res_full_reg, res_full_next;
    category_t        out_cat_reg;
    logic             out_cross_reg;
    logic             out_full_reg;

    formation_t       in_hi, in_lo;
    logic             issue;
    logic             full;
    logic [CNT_W-1:0] base_idx;
    logic [SUM_W-1:0] cat_sum;

    assign in_hi = (formation_a > formation_b) ? formation_a : formation_b;
    assign in_lo = (formation_a > formation_b) ? formation_b : formation_a;

    assign full  = (count_reg == CNT_W'(MAX_PAIRS));
    assign issue = cmd.search && (rd_idx_reg < count_reg);

    assign status.in_same  = (formation_a == formation_b);
    assign status.hit      = cmp_vld_reg && (ram_rd_data == key_reg);
    assign status.miss_end = !cmp_vld_reg && (rd_idx_reg >= count_reg);

    // category base: matched position on a hit, current fill on a miss
    assign base_idx = cmd.take_hit ? cmp_idx_reg : count_reg;
    assign cat_sum  = SUM_W'(fcount_reg) + SUM_W'(base_idx);

    assign ram_rd_en   = issue;
    assign ram_rd_addr = rd_idx_reg[AW-1:0];
    assign ram_wr_en   = cmd.take_miss && !full;
    assign ram_wr_addr = count_reg[AW-1:0];
    assign ram_wr_data = key_reg;

    assign category   = out_cat_reg;
    assign crossing   = out_cross_reg;
    assign table_full = out_full_reg;

    always_comb
    begin
        key_next       = key_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        count_next     = count_reg;
        res_cat_next   = res_cat_reg;
        res_cross_next = res_cross_reg;
        res_full_next  = res_full_reg;

        if (cmd.load_in)
        begin
            key_next       = {in_hi, in_lo};
            rd_idx_next    = '0;
            cmp_vld_next   = 1'b0;
            res_cat_next   = CATEGORY_W'(formation_a);
            res_cross_next = 1'b0;
            res_full_next  = 1'b0;
        end
        else if (cmd.search)
        begin
            cmp_vld_next = issue;
            if (issue)
            begin
                rd_idx_next  = rd_idx_reg + 1'b1;
                cmp_idx_next = rd_idx_reg;
            end
        end

        if (cmd.take_hit)
        begin
            res_cat_next   = cat_sum[CATEGORY_W-1:0];
            res_cross_next = 1'b1;
            res_full_next  = 1'b0;
        end
        else if (cmd.take_miss)
        begin
            res_cross_next = 1'b1;
            if (full)
            begin
                res_cat_next  = '0;
                res_full_next = 1'b1;
            end
            else
            begin
                res_cat_next  = cat_sum[CATEGORY_W-1:0];
                res_full_next = 1'b0;
                count_next    = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg  <= '0;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fcount_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        cmp_idx_reg   <= cmp_idx_next;
        res_cat_reg   <= res_cat_next;
        res_cross_reg <= res_cross_next;
        res_full_reg  <= res_full_next;
        if (cmd.push)
        begin
            out_cat_reg   <= res_cat_reg;
            out_cross_reg <= res_cross_reg;
            out_full_reg  <= res_full_reg;
        end
    end

endmodule

`default_nettype wire

[hdl/formation_pair_category_table.sv]
// ----------------------------------------------------------------------------
// formation_pair_category_table
// Maps a cell connection's two formation indices to a formation or pair
// category, keeping a table of distinct ordered formation pairs.
// ----------------------------------------------------------------------------
// Sequence: equal indices skip the table walk and go straight to the result;
//   a differing pair walks the n pairs held and ends early on a hit, or
//   appends itself (or flags a full table) on a miss.
// Table walk: linear, through the single read port, one entry a cycle; a new
//   connection is taken only after the previous one has left the walk.
// Reset: pair count, formation_count and all handshake state clear at once;
//   table contents are left as is (only entries below the count are read).
// ----------------------------------------------------------------------------
`default_nettype none

module formation_pair_category_table #(
    parameter int MAX_PAIRS = fpct_pkg::MAX_PAIRS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    fpct_conn_if.sink              connection,
    fpct_result_if.source          result,
    input  wire logic              cfg_wr_en,
    input  wire fpct_pkg::fcount_t cfg_wr_data
);
    import fpct_pkg::*;

    localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    fpct_cmd_t    cmd;
    fpct_status_t status;

    // pair table port signals
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    pair_key_t     ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    pair_key_t     ram_rd_data;

    // Sequencer. A transfer is taken only in idle; the output register lets
    // the next connection come in while the previous result still waits.
    fpct_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .conn_valid (connection.valid),
        .conn_ready (connection.ready),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Key ordering (larger index in the high byte), compare pipeline
    // (address issued one cycle, registered data compared the next),
    // append logic and category adder (formation_count + position, mod 512).
    fpct_dp #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .formation_a (connection.formation_a),
        .formation_b (connection.formation_b),
        .category    (result.category),
        .crossing    (result.crossing),
        .table_full  (result.table_full),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Pair table storage: MAX_PAIRS ordered keys, filled in arrival order.
    fpct_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_PAIRS)
    ) u_pair_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire
